// ===== rtl/tjsg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Teleop jog setpoint generator package
// Shared widths, register indexes, lane control bundle and the box clamp.
// ----------------------------------------------------------------------------
package tjsg_pkg;

   localparam int AXES       = 3;
   localparam int COORD_W    = 20;
   localparam int STICK_W    = 16;
   localparam int GAIN_W     = 20;
   localparam int DB_W       = 15;
   localparam int MAG_W      = STICK_W + 1;
   localparam int PROD_W     = STICK_W + GAIN_W + 1;
   localparam int RND_W      = PROD_W + 1;
   localparam int FRAC_SHIFT = 14;
   localparam int STEP_W     = RND_W - FRAC_SHIFT;
   localparam int SUM_W      = STEP_W + 1;
   localparam int REG_W      = AXES * COORD_W;
   localparam int CSR_IDX_W  = 3;

   localparam logic [RND_W-1:0] ROUND_BIAS = RND_W'(1) << (FRAC_SHIFT - 1);

   localparam logic [REG_W-1:0] LOWER_RESET = {AXES{1'b1, {(COORD_W-1){1'b0}}}};
   localparam logic [REG_W-1:0] UPPER_RESET = {AXES{1'b0, {(COORD_W-1){1'b1}}}};
   localparam logic [DB_W-1:0]  DEADBAND_RESET = DB_W'(164);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [STEP_W-1:0]  step_type;
   typedef logic signed [SUM_W-1:0]   sum_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JOG_MODE = 3'd0,
      CSR_NEUTRAL  = 3'd1,
      CSR_SCALE    = 3'd2,
      CSR_LOWER    = 3'd3,
      CSR_UPPER    = 3'd4,
      CSR_DEADBAND = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic advance;
      logic jog_mode;
      logic first;
      logic on;
   } lane_ctrl_type;

   // raise to the lower limit, then lower to the upper limit
   function automatic coord_type clamp_coord(input sum_type v, input coord_type lo,
                                             input coord_type hi);
      sum_type lo_w;
      sum_type hi_w;
      sum_type r;
      lo_w = SUM_W'(lo);
      hi_w = SUM_W'(hi);
      r    = v;
      if (r < lo_w) r = lo_w;
      if (r > hi_w) r = hi_w;
      return r[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tjsg_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Teleop jog setpoint lane
// One axis: stick times gain with rounding, measured clamp and deadband test
// in the first stage; held or offset update and target clamp in the second.
// ----------------------------------------------------------------------------
module tjsg_lane (
   input  wire                                   clock,
   input  wire                                   reset,
   input  tjsg_pkg::lane_ctrl_type               ctrl,
   input  wire signed [tjsg_pkg::STICK_W-1:0]    stick,
   input  wire signed [tjsg_pkg::COORD_W-1:0]    meas,
   input  wire signed [tjsg_pkg::COORD_W-1:0]    neutral,
   input  wire        [tjsg_pkg::GAIN_W-1:0]     gain,
   input  wire signed [tjsg_pkg::COORD_W-1:0]    lower,
   input  wire signed [tjsg_pkg::COORD_W-1:0]    upper,
   input  wire        [tjsg_pkg::DB_W-1:0]       deadband,
   output tjsg_pkg::coord_type                   target
);

   logic signed [tjsg_pkg::GAIN_W:0]   gain_s;
   logic signed [tjsg_pkg::PROD_W-1:0] prod;
   logic        [tjsg_pkg::RND_W-1:0]  rnd;
   logic        [tjsg_pkg::MAG_W-1:0]  mag;
   tjsg_pkg::step_type                 step_in;
   tjsg_pkg::step_type                 step_ff;
   tjsg_pkg::coord_type                meas_in;
   tjsg_pkg::coord_type                meas_ff;
   logic                               jog_in;
   logic                               jog_ff;
   tjsg_pkg::coord_type                held_in;
   tjsg_pkg::coord_type                held_ff;
   tjsg_pkg::coord_type                base;
   tjsg_pkg::step_type                 step_eff;
   tjsg_pkg::sum_type                  sum_v;
   tjsg_pkg::coord_type                clamped;

   always_comb begin
      gain_s  = {1'b0, gain};
      prod    = stick * gain_s;
      rnd     = {prod[tjsg_pkg::PROD_W-1], prod} + tjsg_pkg::ROUND_BIAS;
      step_in = rnd[tjsg_pkg::RND_W-1:tjsg_pkg::FRAC_SHIFT];
      mag     = stick[tjsg_pkg::STICK_W-1] ? (~{1'b1, stick} + 1'b1) : {1'b0, stick};
      jog_in  = mag > tjsg_pkg::MAG_W'(deadband);
      meas_in = tjsg_pkg::clamp_coord(tjsg_pkg::SUM_W'(meas), lower, upper);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         step_ff <= step_in;
         meas_ff <= meas_in;
         jog_ff  <= jog_in;
      end
   end

   always_comb begin
      base     = ctrl.first ? meas_ff : held_ff;
      step_eff = jog_ff ? step_ff : '0;
      if (ctrl.jog_mode) begin
         sum_v = tjsg_pkg::SUM_W'(base) + tjsg_pkg::SUM_W'(step_eff);
      end else begin
         sum_v = tjsg_pkg::SUM_W'(neutral) + tjsg_pkg::SUM_W'(step_ff);
      end
      clamped = tjsg_pkg::clamp_coord(sum_v, lower, upper);
      target  = ctrl.on ? clamped : '0;
      held_in = (ctrl.advance && ctrl.on && ctrl.jog_mode) ? clamped : held_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/tjsg_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Teleop jog setpoint merge
// Gather the three lane targets and the active flag into the result register.
// ----------------------------------------------------------------------------
module tjsg_merge (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         advance,
   input  wire                         active,
   input  tjsg_pkg::coord_type         target [tjsg_pkg::AXES],
   output logic                        rsp_tvalid,
   input  wire                         rsp_tready,
   output logic [63:0]                 rsp_tdata,   // target_x, target_y, target_z, pad
   output logic                        rsp_tuser    // teleop_active
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [tjsg_pkg::REG_W-1:0]    data_ff;
   logic [tjsg_pkg::REG_W-1:0]    data_in;
   logic                          user_ff;

   always_comb begin
      for (int a = 0; a < tjsg_pkg::AXES; a++) begin
         data_in[a*tjsg_pkg::COORD_W +: tjsg_pkg::COORD_W] = target[a];
      end
      if (advance) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
         user_ff <= active;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(64 - tjsg_pkg::REG_W){1'b0}}, data_ff};
   assign rsp_tuser  = user_ff;

endmodule
`default_nettype wire

// ===== rtl/teleop_jog_setpoint_generator.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Teleop jog setpoint generator
// Turns radio sticks and a teleop switch into a clamped three-axis target.
// ----------------------------------------------------------------------------
// req_ carries one word per radio tick: sticks and measured position in
// tdata, the teleop switch in tuser. rsp_ returns one word per request: the
// target in tdata, teleop_active in tuser (target is zero when inactive).
// csr_ writes one configuration register per handshake; csr_ready is always
// high. Write it only while no word is in flight.
// Throughput is one word per cycle while the receiver does not stall: three
// axis lanes each hold one multiplier stage and one add and clamp stage,
// and the held position loop closes in the second stage, so consecutive
// words follow back to back.
// When the receiver stalls, the result register holds its word and the
// first stage still takes one more request; after that req_tready drops.
// Reset empties both stages, clears the held position and the teleop latch,
// and loads the register defaults (jog mode, full workspace box).
// ----------------------------------------------------------------------------
module teleop_jog_setpoint_generator (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire  [111:0]                        req_tdata,  // stick_x, stick_y, stick_z,
                                                           // meas_x, meas_y, meas_z, pad
   input  wire                                 req_tuser,  // teleop_on
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [63:0]                         rsp_tdata,  // target_x, target_y, target_z, pad
   output logic                                rsp_tuser,  // teleop_active
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire  [tjsg_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [tjsg_pkg::REG_W-1:0]          csr_data
);

   localparam int MEAS_BASE = tjsg_pkg::AXES * tjsg_pkg::STICK_W;

   logic                        jog_mode_ff;
   logic [tjsg_pkg::REG_W-1:0]  neutral_ff;
   logic [tjsg_pkg::REG_W-1:0]  scale_ff;
   logic [tjsg_pkg::REG_W-1:0]  lower_ff;
   logic [tjsg_pkg::REG_W-1:0]  upper_ff;
   logic [tjsg_pkg::DB_W-1:0]   deadband_ff;

   logic                        v1_ff;
   logic                        v1_in;
   logic                        on1_ff;
   logic                        was_teleop_ff;
   logic                        was_teleop_in;
   logic                        load;
   logic                        advance;
   tjsg_pkg::lane_ctrl_type     ctrl;
   tjsg_pkg::coord_type         target [tjsg_pkg::AXES];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         jog_mode_ff <= 1'b1;
         neutral_ff  <= '0;
         scale_ff    <= '0;
         lower_ff    <= tjsg_pkg::LOWER_RESET;
         upper_ff    <= tjsg_pkg::UPPER_RESET;
         deadband_ff <= tjsg_pkg::DEADBAND_RESET;
      end else if (csr_valid) begin
         case (tjsg_pkg::csr_index_type'(csr_index))
            tjsg_pkg::CSR_JOG_MODE: jog_mode_ff <= csr_data[0];
            tjsg_pkg::CSR_NEUTRAL:  neutral_ff  <= csr_data;
            tjsg_pkg::CSR_SCALE:    scale_ff    <= csr_data;
            tjsg_pkg::CSR_LOWER:    lower_ff    <= csr_data;
            tjsg_pkg::CSR_UPPER:    upper_ff    <= csr_data;
            tjsg_pkg::CSR_DEADBAND: deadband_ff <= csr_data[tjsg_pkg::DB_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      advance       = v1_ff && (!rsp_tvalid || rsp_tready);
      req_tready    = !v1_ff || advance;
      load          = req_tvalid && req_tready;
      v1_in         = load ? 1'b1 : (advance ? 1'b0 : v1_ff);
      was_teleop_in = advance ? on1_ff : was_teleop_ff;
      ctrl.load     = load;
      ctrl.advance  = advance;
      ctrl.jog_mode = jog_mode_ff;
      ctrl.first    = !was_teleop_ff;
      ctrl.on       = on1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         was_teleop_ff <= 1'b0;
      end else begin
         v1_ff         <= v1_in;
         was_teleop_ff <= was_teleop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         on1_ff <= req_tuser;
      end
   end

   for (genvar a = 0; a < tjsg_pkg::AXES; a++) begin : g_lane
      tjsg_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .stick    (req_tdata[a*tjsg_pkg::STICK_W +: tjsg_pkg::STICK_W]),
         .meas     (req_tdata[MEAS_BASE + a*tjsg_pkg::COORD_W +: tjsg_pkg::COORD_W]),
         .neutral  (neutral_ff[a*tjsg_pkg::COORD_W +: tjsg_pkg::COORD_W]),
         .gain     (scale_ff[a*tjsg_pkg::GAIN_W +: tjsg_pkg::GAIN_W]),
         .lower    (lower_ff[a*tjsg_pkg::COORD_W +: tjsg_pkg::COORD_W]),
         .upper    (upper_ff[a*tjsg_pkg::COORD_W +: tjsg_pkg::COORD_W]),
         .deadband (deadband_ff),
         .target   (target[a])
      );
   end

   tjsg_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .active     (on1_ff),
      .target     (target),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted request word did not reach the first stage");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !advance && !load |=> v1_ff)
      else $error("first stage word lost while stalled");

   a_advance_presents: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced word not presented on the response side");

   a_teleop_latch: assert property (@(posedge clock) disable iff (reset)
      advance |=> was_teleop_ff == $past(on1_ff))
      else $error("teleop latch did not follow the advanced word");

   a_inactive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("inactive response carries a non-zero target");

endmodule
`default_nettype wire

// ===== bench/teleop_jog_setpoint_generator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Teleop jog setpoint generator testbench
// Streams radio ticks into the block under random idling on both sides and
// checks every target word against a predictor that tracks the register
// settings, the held position and the teleop latch. Directed ticks cover
// reset defaults, offset mode, latching, deadband edges and an inverted box;
// random phases sweep the register settings, and one burst backs the block up.
// ----------------------------------------------------------------------------
module teleop_jog_setpoint_generator_test;

   typedef struct packed {
      logic                       active;
      logic [tjsg_pkg::REG_W-1:0] target;
   } setpoint_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_tvalid = 1'b0;
   wire                         req_tready;
   logic [111:0]                req_tdata = '0;   // stick_x, stick_y, stick_z,
                                                  // meas_x, meas_y, meas_z, pad
   logic                        req_tuser = 1'b0; // teleop_on
   wire                         rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   wire  [63:0]                 rsp_tdata;        // target_x, target_y, target_z, pad
   wire                         rsp_tuser;        // teleop_active
   logic                        csr_valid = 1'b0;
   wire                         csr_ready;
   tjsg_pkg::csr_index_type     csr_index = tjsg_pkg::CSR_JOG_MODE;
   logic [tjsg_pkg::REG_W-1:0]  csr_data = '0;

   // register copies and state of the predictor
   logic                        cfg_jog = 1'b1;
   logic [tjsg_pkg::REG_W-1:0]  cfg_neutral = '0;
   logic [tjsg_pkg::REG_W-1:0]  cfg_scale = '0;
   logic [tjsg_pkg::REG_W-1:0]  cfg_lower = tjsg_pkg::LOWER_RESET;
   logic [tjsg_pkg::REG_W-1:0]  cfg_upper = tjsg_pkg::UPPER_RESET;
   logic [tjsg_pkg::DB_W-1:0]   cfg_deadband = tjsg_pkg::DEADBAND_RESET;
   longint                      held_pos [tjsg_pkg::AXES];
   logic                        was_on = 1'b0;

   setpoint_type      setpoint_q [$];
   int                mismatch_count = 0;
   bit                no_idle = 1'b0;
   int                rsp_hold_cycles = 0;

   teleop_jog_setpoint_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("teleop_jog_setpoint_generator: mismatch");
      $finish;
   end

   initial begin
      for (int a = 0; a < tjsg_pkg::AXES; a++) held_pos[a] = 0;
   end

   function automatic longint box_clamp(input longint v, input int axis);
      longint lo;
      longint hi;
      lo = longint'($signed(cfg_lower[tjsg_pkg::COORD_W*axis +: tjsg_pkg::COORD_W]));
      hi = longint'($signed(cfg_upper[tjsg_pkg::COORD_W*axis +: tjsg_pkg::COORD_W]));
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic longint stick_increment(input longint stick, input int axis);
      longint gain;
      gain = longint'(cfg_scale[tjsg_pkg::GAIN_W*axis +: tjsg_pkg::GAIN_W]);
      return (stick * gain + longint'(8192)) >>> tjsg_pkg::FRAC_SHIFT;
   endfunction

   function automatic setpoint_type predict_setpoint(input logic on, input logic [111:0] word);
      setpoint_type sp;
      longint       stick;
      longint       meas;
      longint       mag;
      longint       v;
      int           a;
      sp.active = on;
      sp.target = '0;
      for (a = 0; a < tjsg_pkg::AXES; a++) begin
         stick = longint'($signed(word[tjsg_pkg::STICK_W*a +: tjsg_pkg::STICK_W]));
         meas  = longint'($signed(word[3*tjsg_pkg::STICK_W + tjsg_pkg::COORD_W*a
                                       +: tjsg_pkg::COORD_W]));
         mag   = (stick < 0) ? -stick : stick;
         if (on && cfg_jog) begin
            if (!was_on) held_pos[a] = box_clamp(meas, a);
            v = held_pos[a];
            if (mag > longint'(cfg_deadband)) v += stick_increment(stick, a);
            v = box_clamp(v, a);
            held_pos[a] = v;
            sp.target[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W] = v[tjsg_pkg::COORD_W-1:0];
         end else if (on) begin
            v = longint'($signed(cfg_neutral[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W]))
                + stick_increment(stick, a);
            v = box_clamp(v, a);
            sp.target[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W] = v[tjsg_pkg::COORD_W-1:0];
         end
      end
      was_on = on;
      return sp;
   endfunction

   task automatic report_mismatch(input string what, input logic [tjsg_pkg::REG_W-1:0] got,
                                  input logic [tjsg_pkg::REG_W-1:0] want);
      mismatch_count++;
      if (mismatch_count <= 100)
         $display("%0t: %s: got %h, want %h", $time, what, got, want);
   endtask

   always @(negedge clock) begin
      setpoint_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (setpoint_q.size() == 0) begin
            report_mismatch("result word with nothing expected",
                            rsp_tdata[tjsg_pkg::REG_W-1:0], '0);
         end else begin
            want = setpoint_q.pop_front();
            if (rsp_tuser !== want.active)
               report_mismatch("teleop_active", tjsg_pkg::REG_W'(rsp_tuser),
                               tjsg_pkg::REG_W'(want.active));
            for (int a = 0; a < tjsg_pkg::AXES; a++)
               if (rsp_tdata[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W]
                   !== want.target[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W])
                  report_mismatch($sformatf("target axis %0d", a),
                     tjsg_pkg::REG_W'(rsp_tdata[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W]),
                     tjsg_pkg::REG_W'(want.target[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W]));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_sink
      int gap;
      bit took;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 12);
         if (rsp_hold_cycles != 0) begin
            gap = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            took = rsp_tvalid;
            @(posedge clock);
         end while (!took && rsp_hold_cycles == 0);
      end
   end

   task automatic send_tick(input logic on, input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] sz, input logic [19:0] mx,
                            input logic [19:0] my, input logic [19:0] mz);
      logic [111:0] word;
      int           gap;
      bit           taken;
      word = {4'b0, mz, my, mx, sz, sy, sx};
      gap  = no_idle ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= on;
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      setpoint_q.push_back(predict_setpoint(on, word));
   endtask

   task automatic drain_setpoints();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (setpoint_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input tjsg_pkg::csr_index_type idx,
                                 input logic [tjsg_pkg::REG_W-1:0] value);
      bit taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      csr_valid <= 1'b0;
      case (idx)
         tjsg_pkg::CSR_JOG_MODE: cfg_jog      = value[0];
         tjsg_pkg::CSR_NEUTRAL:  cfg_neutral  = value;
         tjsg_pkg::CSR_SCALE:    cfg_scale    = value;
         tjsg_pkg::CSR_LOWER:    cfg_lower    = value;
         tjsg_pkg::CSR_UPPER:    cfg_upper    = value;
         tjsg_pkg::CSR_DEADBAND: cfg_deadband = value[tjsg_pkg::DB_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_stick();
      int d;
      d = int'(cfg_deadband);
      case ($urandom_range(0, 15))
         0, 1: return 16'($urandom);
         2:    return 16'(d);
         3:    return 16'(-d);
         4:    return 16'(d + 1);
         5:    return 16'(-d - 1);
         6:    return 16'h4000;
         7:    return 16'hC000;
         8:    return 16'h0000;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   function automatic logic [19:0] random_coord();
      case ($urandom_range(0, 9))
         0:       return 20'h80000;
         1:       return 20'h7FFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   task automatic send_random_tick(input logic on);
      send_tick(on, random_stick(), random_stick(), random_stick(),
                random_coord(), random_coord(), random_coord());
   endtask

   task automatic random_settings(input int phase);
      logic [tjsg_pkg::REG_W-1:0] lo_w;
      logic [tjsg_pkg::REG_W-1:0] hi_w;
      logic [tjsg_pkg::REG_W-1:0] gain_w;
      logic [19:0]                p;
      logic [19:0]                q;
      logic [19:0]                t;
      int                         a;
      for (a = 0; a < tjsg_pkg::AXES; a++) begin
         p = random_coord();
         q = random_coord();
         if ($signed(p) > $signed(q) && $urandom_range(0, 9) != 0) begin
            t = p;
            p = q;
            q = t;
         end
         lo_w[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W] = p;
         hi_w[tjsg_pkg::COORD_W*a +: tjsg_pkg::COORD_W] = q;
         case ($urandom_range(0, 3))
            0:       gain_w[tjsg_pkg::GAIN_W*a +: tjsg_pkg::GAIN_W] = 20'($urandom);
            1:       gain_w[tjsg_pkg::GAIN_W*a +: tjsg_pkg::GAIN_W] = 20'hFFFFF;
            default: gain_w[tjsg_pkg::GAIN_W*a +: tjsg_pkg::GAIN_W] =
                        20'($urandom_range(0, 1 << 14));
         endcase
      end
      if (phase == 0) begin
         lo_w   = tjsg_pkg::LOWER_RESET;
         hi_w   = tjsg_pkg::UPPER_RESET;
         gain_w = {tjsg_pkg::AXES{20'hFFFFF}};
      end
      write_register(tjsg_pkg::CSR_JOG_MODE,
                     tjsg_pkg::REG_W'(phase != 2 && $urandom_range(0, 4) != 0));
      write_register(tjsg_pkg::CSR_NEUTRAL, tjsg_pkg::REG_W'({$urandom, $urandom}));
      write_register(tjsg_pkg::CSR_SCALE, gain_w);
      write_register(tjsg_pkg::CSR_LOWER, lo_w);
      write_register(tjsg_pkg::CSR_UPPER, hi_w);
      case (phase)
         1:       write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(0));
         3:       write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(16384));
         4:       write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(15'h7FFF));
         default: write_register(tjsg_pkg::CSR_DEADBAND,
                                 tjsg_pkg::REG_W'($urandom_range(0, 2000)));
      endcase
   endtask

   task automatic test_reset_defaults();
      send_tick(1'b1, 16'h4000, 16'hC000, 16'h0000, 20'h7FFFF, 20'h80000, 20'h00000);
      send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h0001, 20'h12345, 20'hABCDE, 20'h00001);
      send_tick(1'b0, 16'h8000, 16'h7FFF, 16'hFFFF, 20'hFFFFF, 20'h55555, 20'hAAAAA);
      send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 20'h80000, 20'h7FFFF, 20'hFFFFF);
      drain_setpoints();
   endtask

   task automatic test_offset_mode();
      write_register(tjsg_pkg::CSR_JOG_MODE, tjsg_pkg::REG_W'(0));
      write_register(tjsg_pkg::CSR_NEUTRAL, {20'h7FFFF, 20'h80000, 20'h01000});
      write_register(tjsg_pkg::CSR_SCALE, {20'h00001, 20'h10000, 20'hFFFFF});
      // z axis has its lower limit above its upper limit
      write_register(tjsg_pkg::CSR_LOWER, {20'h00100, 20'h80000, 20'hF0000});
      write_register(tjsg_pkg::CSR_UPPER, {20'h00010, 20'h7FFFF, 20'h10000});
      write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(0));
      send_tick(1'b1, 16'h4000, 16'hC000, 16'h8000, 20'h00000, 20'h00000, 20'h00000);
      send_tick(1'b1, 16'hC000, 16'h4000, 16'h7FFF, 20'h7FFFF, 20'h80000, 20'h12345);
      send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      send_tick(1'b0, 16'h4000, 16'h4000, 16'h4000, 20'h00001, 20'h00002, 20'h00003);
      send_tick(1'b1, 16'hFFFF, 16'h0001, 16'h4000, 20'h55555, 20'hAAAAA, 20'h00000);
      send_tick(1'b1, 16'h8000, 16'h8000, 16'h8000, 20'h80000, 20'h80000, 20'h80000);
      drain_setpoints();
   endtask

   task automatic test_latch_and_deadband();
      write_register(tjsg_pkg::CSR_LOWER, tjsg_pkg::LOWER_RESET);
      write_register(tjsg_pkg::CSR_UPPER, tjsg_pkg::UPPER_RESET);
      write_register(tjsg_pkg::CSR_SCALE, {tjsg_pkg::AXES{20'h10000}});
      write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(100));
      // teleop held on across the switch to jog mode: no relatch
      send_tick(1'b1, 16'h1000, 16'h0000, 16'hF000, 20'h11111, 20'h22222, 20'h33333);
      drain_setpoints();
      write_register(tjsg_pkg::CSR_JOG_MODE, tjsg_pkg::REG_W'(1));
      send_tick(1'b1, 16'd100, -16'sd100, 16'd101, 20'h44444, 20'h55555, 20'h66666);
      send_tick(1'b1, -16'sd101, 16'h4000, 16'hC000, 20'h00000, 20'h00000, 20'h00000);
      send_tick(1'b0, 16'h4000, 16'h4000, 16'h4000, 20'h7FFFF, 20'h7FFFF, 20'h7FFFF);
      send_tick(1'b1, 16'h0000, 16'h0000, 16'h0000, 20'h00000, 20'h80000, 20'h7FFFF);
      drain_setpoints();
      write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(16384));
      send_tick(1'b1, 16'h4000, 16'hC000, 16'h8000, 20'h00000, 20'h00000, 20'h00000);
      drain_setpoints();
      write_register(tjsg_pkg::CSR_DEADBAND, tjsg_pkg::REG_W'(0));
      send_tick(1'b1, 16'h0001, 16'hFFFF, 16'h0000, 20'h00000, 20'h00000, 20'h00000);
      drain_setpoints();
      write_register(tjsg_pkg::CSR_SCALE, {tjsg_pkg::AXES{20'hFFFFF}});
      send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 20'h00000, 20'h00000, 20'h00000);
      send_tick(1'b1, 16'h7FFF, 16'h8000, 16'h7FFF, 20'h00000, 20'h00000, 20'h00000);
      drain_setpoints();
   endtask

   task automatic test_backpressure();
      no_idle = 1'b1;
      rsp_hold_cycles = 40;
      repeat (24) send_random_tick($urandom_range(0, 7) != 0);
      drain_setpoints();
      repeat (6) send_random_tick(1'b1);
      drain_setpoints();
      no_idle = 1'b0;
   endtask

   task automatic test_random_traffic();
      int sent;
      int run;
      for (int phase = 0; phase < 6; phase++) begin
         random_settings(phase);
         no_idle = ($urandom_range(0, 3) == 0);
         sent = 0;
         while (sent < 66) begin
            run = $urandom_range(1, 16);
            repeat (run) send_random_tick($urandom_range(0, 9) != 0);
            sent += run;
            run = $urandom_range(1, 2);
            repeat (run) send_random_tick(1'b0);
            sent += run;
         end
         drain_setpoints();
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_offset_mode();
      test_latch_and_deadband();
      test_backpressure();
      test_random_traffic();
      drain_setpoints();
      if (mismatch_count == 0)
         $display("teleop_jog_setpoint_generator: match");
      else
         $display("teleop_jog_setpoint_generator: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tjsg_pkg.sv
rtl/tjsg_lane.sv
rtl/tjsg_merge.sv
rtl/teleop_jog_setpoint_generator.sv
bench/teleop_jog_setpoint_generator_test.sv
